// ----- hw/rtl/sol_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sol_pkg
// Shared types and codes for the self-organizing list.
// ----------------------------------------------------------------------------
package sol_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PAY_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [APB_AW-1:0] REG_REORDER_MODE = 3'd0;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic MODE_TRANSPOSE = 1'b0;
  localparam logic MODE_TO_FRONT  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_FOUND    = 2'd1,
    STATUS_MISSING  = 2'd2,
    STATUS_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_e;

  typedef struct packed {
    logic do_insert;
    logic do_lookup;
    logic to_front;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/sol_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sol_cell
// One list slot: holds a key and payload, flags a key match and shifts or
// swaps with its neighbors under a broadcast control word.
// ----------------------------------------------------------------------------
module sol_cell (
  input  logic                          clk_i,
  input  logic                          valid_i,
  input  logic                          capture_i,
  input  logic [sol_pkg::KEY_W-1:0]     cmp_key_i,
  input  sol_pkg::cell_ctl_t            ctl_i,
  input  logic                          found_i,
  input  logic                          hit_before_i,
  output logic                          hit_before_o,
  output logic                          first_o,
  input  logic                          next_first_i,
  input  logic [sol_pkg::KEY_W-1:0]     prev_key_i,
  input  logic [sol_pkg::PAY_W-1:0]     prev_pay_i,
  input  logic [sol_pkg::KEY_W-1:0]     next_key_i,
  input  logic [sol_pkg::PAY_W-1:0]     next_pay_i,
  output logic [sol_pkg::KEY_W-1:0]     key_o,
  output logic [sol_pkg::PAY_W-1:0]     pay_o
);

  logic                      match_q;
  logic [sol_pkg::KEY_W-1:0] key_q, key_d;
  logic [sol_pkg::PAY_W-1:0] pay_q, pay_d;

  assign first_o      = match_q & ~hit_before_i;
  assign hit_before_o = hit_before_i | match_q;

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (ctl_i.do_insert) begin
      key_d = prev_key_i;
      pay_d = prev_pay_i;
    end else if (ctl_i.do_lookup && found_i) begin
      if (ctl_i.to_front) begin
        if (!hit_before_i) begin
          key_d = prev_key_i;
          pay_d = prev_pay_i;
        end
      end else if (first_o) begin
        key_d = prev_key_i;
        pay_d = prev_pay_i;
      end else if (next_first_i) begin
        key_d = next_key_i;
        pay_d = next_pay_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      match_q <= valid_i & (key_q == cmp_key_i);
    end
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule

// ----- hw/rtl/self_organizing_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// self_organizing_list
// Bounded keyed list that reorders itself on lookup hits. At acceptance every
// cell compares its key with the request key and registers the match; in the
// update state, once the output register is free, the first hit is resolved
// along the cell chain, the list shifts or swaps in place and the result is
// written to the output register. A new request is taken again in the cycle
// after that, while the previous result may still wait on the output. Inserts
// go to the head and are rejected with a full status when all slots are taken.
// Register 0 (byte address 0) selects transpose (0) or move-to-front (1).
// ----------------------------------------------------------------------------
module self_organizing_list #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sol_pkg::APB_AW-1:0]          paddr,
  input  logic [sol_pkg::APB_DW-1:0]          pwdata,
  output logic [sol_pkg::APB_DW-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic signed [sol_pkg::KEY_W-1:0]    contact_key_i,
  input  logic [sol_pkg::PAY_W-1:0]           entry_payload_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sol_pkg::STATUS_W-1:0]        status_o,
  output logic [sol_pkg::POS_W-1:0]           hit_position_o,
  output logic [sol_pkg::PAY_W-1:0]           hit_payload_o,
  output logic [sol_pkg::COUNT_W-1:0]         entry_count_o
);

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);

  sol_pkg::state_e           st_q, st_d;
  logic                      mode_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      req_type_q;
  logic [sol_pkg::KEY_W-1:0] req_key_q;
  logic [sol_pkg::PAY_W-1:0] req_pay_q;

  logic                      out_valid_q;
  logic [sol_pkg::STATUS_W-1:0] status_q;
  logic [sol_pkg::POS_W-1:0] pos_q;
  logic [sol_pkg::PAY_W-1:0] hit_pay_q;
  logic [sol_pkg::COUNT_W-1:0] ecount_q;

  logic in_fire, upd_fire, out_free, full, found;
  logic [sol_pkg::POS_W-1:0] pos_v;
  logic [sol_pkg::PAY_W-1:0] hit_pay_v;
  logic [sol_pkg::PAY_W-1:0] head_pay;
  logic [sol_pkg::STATUS_W-1:0] status_v;
  sol_pkg::cell_ctl_t ctl;

  logic [sol_pkg::KEY_W-1:0] cell_key [LIST_DEPTH];
  logic [sol_pkg::PAY_W-1:0] cell_pay [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]     first;
  logic [LIST_DEPTH:0]       hit_chain;

  assign pready     = 1'b1;
  assign prdata     = (paddr == sol_pkg::REG_REORDER_MODE) ?
                      {{(sol_pkg::APB_DW-1){1'b0}}, mode_q} : '0;
  assign in_stall_o = (st_q == sol_pkg::ST_UPDATE);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign upd_fire   = (st_q == sol_pkg::ST_UPDATE) & out_free;
  assign full       = (count_q == CNT_W'(LIST_DEPTH));
  assign found      = hit_chain[LIST_DEPTH];

  assign ctl.do_insert = upd_fire & (req_type_q == sol_pkg::REQ_INSERT) & ~full;
  assign ctl.do_lookup = upd_fire & (req_type_q == sol_pkg::REQ_LOOKUP);
  assign ctl.to_front  = (mode_q == sol_pkg::MODE_TO_FRONT);

  assign head_pay = (req_type_q == sol_pkg::REQ_INSERT) ? req_pay_q : hit_pay_v;
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [sol_pkg::KEY_W-1:0] prev_key, next_key;
    logic [sol_pkg::PAY_W-1:0] prev_pay, next_pay;
    logic                      next_first;

    if (i == 0) begin : g_head
      assign prev_key = req_key_q;
      assign prev_pay = head_pay;
    end else begin : g_body
      assign prev_key = cell_key[i-1];
      assign prev_pay = cell_pay[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign next_key   = cell_key[i];
      assign next_pay   = cell_pay[i];
      assign next_first = 1'b0;
    end else begin : g_mid
      assign next_key   = cell_key[i+1];
      assign next_pay   = cell_pay[i+1];
      assign next_first = first[i+1];
    end

    sol_cell u_cell (
      .clk_i        (clk_i),
      .valid_i      (CNT_W'(i) < count_q),
      .capture_i    (in_fire),
      .cmp_key_i    ($unsigned(contact_key_i)),
      .ctl_i        (ctl),
      .found_i      (found),
      .hit_before_i (hit_chain[i]),
      .hit_before_o (hit_chain[i+1]),
      .first_o      (first[i]),
      .next_first_i (next_first),
      .prev_key_i   (prev_key),
      .prev_pay_i   (prev_pay),
      .next_key_i   (next_key),
      .next_pay_i   (next_pay),
      .key_o        (cell_key[i]),
      .pay_o        (cell_pay[i])
    );
  end

  always_comb begin
    pos_v     = '0;
    hit_pay_v = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (first[i]) begin
        pos_v     = pos_v | sol_pkg::POS_W'(i);
        hit_pay_v = hit_pay_v | cell_pay[i];
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    status_v = sol_pkg::STATUS_MISSING;
    if (req_type_q == sol_pkg::REQ_INSERT) begin
      if (full) begin
        status_v = sol_pkg::STATUS_FULL;
      end else begin
        status_v = sol_pkg::STATUS_INSERTED;
        count_d  = count_q + CNT_W'(1);
      end
    end else if (found) begin
      status_v = sol_pkg::STATUS_FOUND;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      sol_pkg::ST_IDLE:   if (in_fire) st_d = sol_pkg::ST_UPDATE;
      sol_pkg::ST_UPDATE: if (upd_fire) st_d = sol_pkg::ST_IDLE;
      default:            st_d = sol_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= sol_pkg::ST_IDLE;
      mode_q      <= sol_pkg::MODE_TRANSPOSE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (psel && penable && pwrite && pready && paddr == sol_pkg::REG_REORDER_MODE) begin
        mode_q <= pwdata[0];
      end
      if (upd_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_type_q <= req_type_i;
      req_key_q  <= $unsigned(contact_key_i);
      req_pay_q  <= entry_payload_i;
    end
    if (upd_fire) begin
      status_q  <= status_v;
      pos_q     <= (status_v == sol_pkg::STATUS_FOUND) ? pos_v : '0;
      hit_pay_q <= (status_v == sol_pkg::STATUS_FOUND) ? hit_pay_v : '0;
      ecount_q  <= sol_pkg::COUNT_W'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign hit_position_o = pos_q;
  assign hit_payload_o  = hit_pay_q;
  assign entry_count_o  = ecount_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LIST_DEPTH))
    else $error("entry count exceeds list depth");

  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("request accepted while previous one in update");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("entry count changed by other than one");

  a_one_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == sol_pkg::ST_UPDATE) |-> $onehot0(first))
    else $error("more than one first hit");

endmodule
